/* hw/rtl/dbce_pkg.sv */
// Shared types, constants and DES tables for the block-chaining encryptor.
package dbce_pkg;

    localparam int BLOCK_W = 64;
    localparam int COUNT_W = 4;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ECB  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CBC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PCBC = 2'd2;

    localparam logic [BLOCK_W-1:0] PAD_BLOCK = 64'h0808080808080808;

    // One job for the DES core: a block already padded, plus framing.
    typedef struct packed {
        logic [BLOCK_W-1:0] data;
        logic               msg_end;  // last result of the message
        logic               first;    // chaining starts from the IV
    } job_t;

    typedef logic [7:0] tab8_t [64];

    localparam tab8_t TAB_IP = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4, 62,54,46,38,30,22,14,6,
        64,56,48,40,32,24,16,8, 57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam tab8_t TAB_FP = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31, 38,6,46,14,54,22,62,30,
        37,5,45,13,53,21,61,29, 36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam logic [7:0] TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    localparam logic [7:0] TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam logic [7:0] TAB_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
        19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam logic [7:0] TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
    localparam logic [15:0] ROT_TWO = 16'b0111_1110_1111_1100; // bit i: round i shifts by 2

    localparam logic [3:0] TAB_S [8][64] = '{
     '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
       4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
     '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
       0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
     '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
       13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
     '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
       10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
     '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
       4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
     '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
       9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
     '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
       1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
     '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
       7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] initial_perm(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(TAB_IP[i])];
        return r;
    endfunction

    function automatic logic [63:0] final_perm(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(TAB_FP[i])];
        return r;
    endfunction

    function automatic logic [55:0] pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64 - int'(TAB_PC1[i])];
        return r;
    endfunction

    function automatic logic [47:0] pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56 - int'(TAB_PC2[i])];
        return r;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] o;
        logic [5:0]  six;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TAB_E[i])];
        x = x ^ k;
        for (int i = 0; i < 8; i++)
        begin
            six = x[47-6*i -: 6];
            o[31-4*i -: 4] = TAB_S[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = o[32 - int'(TAB_P[i])];
        return p;
    endfunction

endpackage

/* hw/rtl/dbce_stream_if.sv */
// Valid/ready stream interface carrying one payload.
interface dbce_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/dbce_front.sv */
// Front end: pads the last beat and splits a full last beat into two jobs.
module dbce_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dbce_pkg::BLOCK_W-1:0] plain_block,
    input  logic [dbce_pkg::COUNT_W-1:0] byte_count,
    input  logic                         last,
    output logic                         job_valid,
    input  logic                         job_ready,
    output dbce_pkg::job_t               job
);
    // Pending pad block after a full last beat.
    logic pad_pend_reg, pad_pend_next;
    logic first_reg, first_next;
    logic [dbce_pkg::BLOCK_W-1:0] padded;
    logic [7:0] pad_byte;

    always_comb
    begin
        pad_byte = 8'd8 - {4'd0, byte_count};
        padded = plain_block;
        if (last && byte_count < 4'd8)
        begin
            for (int i = 0; i < 8; i++)
                if (i >= int'(byte_count)) padded[63-8*i -: 8] = pad_byte;
        end
    end

    assign in_ready  = job_ready && !pad_pend_reg;
    assign job_valid = pad_pend_reg || in_valid;

    always_comb
    begin
        if (pad_pend_reg)
        begin
            job.data    = dbce_pkg::PAD_BLOCK;
            job.msg_end = 1'b1;
            job.first   = 1'b0;
        end
        else
        begin
            job.data    = padded;
            job.msg_end = last && byte_count < 4'd8;
            job.first   = first_reg;
        end
    end

    always_comb
    begin
        pad_pend_next = pad_pend_reg;
        first_next    = first_reg;
        if (pad_pend_reg && job_ready)
        begin
            pad_pend_next = 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            first_next    = last;
            pad_pend_next = last && byte_count >= 4'd8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_pend_reg <= 1'b0;
            first_reg    <= 1'b1;
        end
        else
        begin
            pad_pend_reg <= pad_pend_next;
            first_reg    <= first_next;
        end
    end
endmodule

/* hw/rtl/dbce_queue.sv */
// Two-entry job queue between front and back.
module dbce_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  dbce_pkg::job_t wr_job,
    output logic           rd_valid,
    input  logic           rd_ready,
    output dbce_pkg::job_t rd_job
);
    dbce_pkg::job_t slot_reg [2];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_job   = slot_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wptr_reg] <= wr_job;
    end
endmodule

/* hw/rtl/dbce_back.sv */
// Back end: chaining, DES one round per cycle unless held, output register.
module dbce_back #(
    parameter int ROUNDS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dbce_pkg::BLOCK_W-1:0] des_key,
    input  logic [dbce_pkg::BLOCK_W-1:0] init_vector,
    input  logic [dbce_pkg::MODE_W-1:0]  chain_mode,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  dbce_pkg::job_t               job,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dbce_pkg::BLOCK_W-1:0] cipher_block,
    output logic                         last_of_message
);
    localparam int RND_W = $clog2(ROUNDS);

    logic                  busy_reg, busy_next;
    logic [RND_W-1:0]      rnd_reg, rnd_next;
    logic [31:0]           l_reg, l_next, r_reg, r_next;
    logic [27:0]           c_reg, c_next, d_reg, d_next;
    logic [63:0]           plain_reg;
    logic                  end_reg;
    logic [63:0]           chain_reg, chain_next;
    logic                  ov_reg, ov_next;
    logic [63:0]           ob_reg;
    logic                  ol_reg;

    logic [63:0] prev, x, ipx, cipher, done_chain;
    logic [55:0] cd0;
    logic [27:0] c_rot, d_rot;
    logic        two;
    logic        start, done, out_free, last_rnd, advance;

    assign out_free  = !ov_reg || out_ready;
    assign last_rnd  = busy_reg && rnd_reg == RND_W'(ROUNDS - 1);
    // A held result freezes the core on its last round.
    assign done      = last_rnd && out_free;
    assign advance   = busy_reg && (!last_rnd || out_free);
    // Next job starts in the cycle the current one retires.
    assign job_ready = !busy_reg || done;
    assign start     = job_valid && job_ready;

    always_comb
    begin
        two = dbce_pkg::ROT_TWO[rnd_reg];
        c_rot = two ? {c_reg[25:0], c_reg[27:26]} : {c_reg[26:0], c_reg[27]};
        d_rot = two ? {d_reg[25:0], d_reg[27:26]} : {d_reg[26:0], d_reg[27]};
        l_next = r_reg;
        r_next = l_reg ^ dbce_pkg::feistel(r_reg, dbce_pkg::pc2({c_rot, d_rot}));
        cipher = dbce_pkg::final_perm({r_next, l_next});
        done_chain = (chain_mode == dbce_pkg::MODE_PCBC) ? (cipher ^ plain_reg) : cipher;
        // Chain forward from the block retiring this cycle.
        prev = job.first ? init_vector : (done ? done_chain : chain_reg);
        x    = (chain_mode == dbce_pkg::MODE_ECB) ? job.data : (job.data ^ prev);
        ipx  = dbce_pkg::initial_perm(x);
        cd0  = dbce_pkg::pc1(des_key);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        rnd_next   = rnd_reg;
        chain_next = chain_reg;
        ov_next    = ov_reg && !out_ready;
        c_next     = c_rot;
        d_next     = d_rot;
        if (advance)
        begin
            rnd_next = rnd_reg + RND_W'(1);
        end
        if (done)
        begin
            busy_next  = 1'b0;
            ov_next    = 1'b1;
            chain_next = end_reg ? init_vector : done_chain;
        end
        if (start)
        begin
            busy_next = 1'b1;
            rnd_next  = '0;
            c_next    = cd0[55:28];
            d_next    = cd0[27:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            rnd_reg   <= '0;
            ov_reg    <= 1'b0;
            chain_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            rnd_reg   <= rnd_next;
            ov_reg    <= ov_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            l_reg     <= ipx[63:32];
            r_reg     <= ipx[31:0];
            plain_reg <= job.data;
            end_reg   <= job.msg_end;
        end
        else if (advance)
        begin
            l_reg <= l_next;
            r_reg <= r_next;
        end
        if (start || advance)
        begin
            c_reg <= c_next;
            d_reg <= d_next;
        end
        if (done)
        begin
            ob_reg <= cipher;
            ol_reg <= end_reg;
        end
    end

    assign out_valid       = ov_reg;
    assign cipher_block    = ob_reg;
    assign last_of_message = ol_reg;
endmodule

/* hw/rtl/des_block_chaining_encrypt_top.sv */
// Top level of the DES ECB/CBC/PCBC encryptor with PKCS#5 padding.
//
//   channel   dir   payload
//   in_ch     sink  plain_block[64], byte_count[4], last
//   out_ch    src   cipher_block[64], last_of_message
//   cfg       in    cfg_we, cfg_idx[2], cfg_data[64]
//
// One DES round per cycle while the core is not frozen, in the round loop
// of the back end; a full last beat costs two blocks. Front and back are
// split by a two-entry queue; the result sits in an output register while
// the next block runs, and a result still held there when the next block
// finishes freezes the core on its last round. Reset clears control, the
// configuration registers and the chaining state only.
module des_block_chaining_encrypt_top #(
    parameter int ROUNDS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [dbce_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [dbce_pkg::BLOCK_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dbce_pkg::BLOCK_W-1:0]   plain_block,
    input  logic [dbce_pkg::COUNT_W-1:0]   byte_count,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dbce_pkg::BLOCK_W-1:0]   cipher_block,
    output logic                           last_of_message
);
    logic [63:0] key_reg, iv_reg;
    logic [dbce_pkg::MODE_W-1:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            iv_reg   <= '0;
            mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                dbce_pkg::CFG_KEY:  key_reg  <= cfg_data;
                dbce_pkg::CFG_IV:   iv_reg   <= cfg_data;
                dbce_pkg::CFG_MODE: mode_reg <= cfg_data[dbce_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    dbce_stream_if #(.payload_t(dbce_pkg::job_t)) fq ();
    dbce_stream_if #(.payload_t(dbce_pkg::job_t)) qb ();

    dbce_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .plain_block(plain_block), .byte_count(byte_count), .last(last),
        .job_valid(fq.valid), .job_ready(fq.ready), .job(fq.payload)
    );

    dbce_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq.valid), .wr_ready(fq.ready), .wr_job(fq.payload),
        .rd_valid(qb.valid), .rd_ready(qb.ready), .rd_job(qb.payload)
    );

    dbce_back #(.ROUNDS(ROUNDS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .des_key(key_reg), .init_vector(iv_reg), .chain_mode(mode_reg),
        .job_valid(qb.valid), .job_ready(qb.ready), .job(qb.payload),
        .out_valid(out_valid), .out_ready(out_ready),
        .cipher_block(cipher_block), .last_of_message(last_of_message)
    );
endmodule

/* verif/tb_des_block_chaining_encrypt_top.sv */
`timescale 1ns / 100ps
// Testbench for the DES ECB/CBC/PCBC encryptor with PKCS#5 padding.
module tb_des_block_chaining_encrypt_top;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic [dbce_pkg::BLOCK_W-1:0] plain_block;
        logic [dbce_pkg::COUNT_W-1:0] byte_count;
        logic                         last;
    } plain_beat_t;

    typedef struct packed {
        logic [dbce_pkg::BLOCK_W-1:0] cipher_block;
        logic                         last_of_message;
    } cipher_beat_t;

    class cipher_scoreboard;
        cipher_beat_t expected_q[$];
        logic [63:0]  key_reg;
        logic [63:0]  iv_reg;
        logic [1:0]   mode_reg;
        logic [63:0]  chain_val;
        bit           at_msg_start;
        int           errors;
        int           checked;

        function void clear();
            key_reg = '0;
            iv_reg = '0;
            mode_reg = dbce_pkg::MODE_ECB;
            chain_val = '0;
            at_msg_start = 1'b1;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [dbce_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
            if (idx == dbce_pkg::CFG_KEY)
                key_reg = value;
            else if (idx == dbce_pkg::CFG_IV)
                iv_reg = value;
            else if (idx == dbce_pkg::CFG_MODE)
                mode_reg = value[1:0];
        endfunction

        function logic [63:0] des_block(logic [63:0] blk);
            int          shifts [16];
            logic [55:0] cd;
            logic [27:0] c;
            logic [27:0] d;
            logic [63:0] b;
            logic [63:0] pre;
            logic [63:0] o;
            logic [31:0] l;
            logic [31:0] r;
            logic [31:0] t;
            logic [31:0] sb;
            logic [31:0] f;
            logic [47:0] k;
            logic [47:0] x;
            logic [5:0]  six;
            shifts = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};
            for (int i = 0; i < 56; i++)
                cd[55-i] = key_reg[64 - int'(dbce_pkg::TAB_PC1[i])];
            c = cd[55:28];
            d = cd[27:0];
            for (int i = 0; i < 64; i++) b[63-i] = blk[64 - int'(dbce_pkg::TAB_IP[i])];
            l = b[63:32];
            r = b[31:0];
            for (int rnd = 0; rnd < 16; rnd++)
            begin
                for (int s = 0; s < shifts[rnd]; s++)
                begin
                    c = {c[26:0], c[27]};
                    d = {d[26:0], d[27]};
                end
                cd = {c, d};
                for (int i = 0; i < 48; i++) k[47-i] = cd[56 - int'(dbce_pkg::TAB_PC2[i])];
                for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(dbce_pkg::TAB_E[i])];
                x = x ^ k;
                for (int i = 0; i < 8; i++)
                begin
                    six = x[47-6*i -: 6];
                    sb[31-4*i -: 4] = dbce_pkg::TAB_S[i][{six[5], six[0], six[4:1]}];
                end
                for (int i = 0; i < 32; i++) f[31-i] = sb[32 - int'(dbce_pkg::TAB_P[i])];
                t = l;
                l = r;
                r = t ^ f;
            end
            pre = {r, l};
            for (int i = 0; i < 64; i++) o[63-i] = pre[64 - int'(dbce_pkg::TAB_FP[i])];
            return o;
        endfunction

        function logic [63:0] chain_encrypt(logic [63:0] p);
            logic [63:0] prev;
            logic [63:0] x;
            logic [63:0] c;
            prev = at_msg_start ? iv_reg : chain_val;
            x = (mode_reg == dbce_pkg::MODE_ECB) ? p : (p ^ prev);
            c = des_block(x);
            chain_val = (mode_reg == dbce_pkg::MODE_PCBC) ? (c ^ p) : c;
            at_msg_start = 1'b0;
            return c;
        endfunction

        function void note_input(plain_beat_t beat);
            int           n;
            logic [63:0]  p;
            cipher_beat_t res;
            n = beat.byte_count;
            p = beat.plain_block;
            if (!beat.last || n > 8)
                n = 8;
            if (beat.last && n < 8)
                for (int i = n; i < 8; i++) p[63-8*i -: 8] = 8'(8 - n);
            res.cipher_block = chain_encrypt(p);
            res.last_of_message = beat.last && n < 8;
            expected_q.push_back(res);
            if (beat.last && n == 8)
            begin
                res.cipher_block = chain_encrypt(dbce_pkg::PAD_BLOCK);
                res.last_of_message = 1'b1;
                expected_q.push_back(res);
            end
            if (beat.last)
            begin
                chain_val = iv_reg;
                at_msg_start = 1'b1;
            end
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
        endtask

        task check_result(cipher_beat_t got);
            cipher_beat_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected beat", got.cipher_block, '0);
                return;
            end
            want = expected_q.pop_front();
            if (got.cipher_block !== want.cipher_block)
                report_mismatch("cipher_block", got.cipher_block, want.cipher_block);
            if (got.last_of_message !== want.last_of_message)
                report_mismatch("last_of_message", 64'(got.last_of_message),
                                64'(want.last_of_message));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [dbce_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [dbce_pkg::BLOCK_W-1:0]   cfg_data;

    dbce_stream_if #(.payload_t(plain_beat_t))  in_ch ();
    dbce_stream_if #(.payload_t(cipher_beat_t)) out_ch ();

    cipher_scoreboard sb;
    bit idle_en;
    bit hold_off_req;
    int idle_cycles;
    int sent_items;
    int msg_count;

    des_block_chaining_encrypt_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_data        (cfg_data),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .plain_block     (in_ch.payload.plain_block),
        .byte_count      (in_ch.payload.byte_count),
        .last            (in_ch.payload.last),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .cipher_block    (out_ch.payload.cipher_block),
        .last_of_message (out_ch.payload.last_of_message)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.payload);
        if (rst_n && ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("FAIL des_block_chaining_encrypt_top");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task write_reg(logic [dbce_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task send_beat(logic [63:0] plain, int count, bit is_last);
        plain_beat_t beat;
        beat.plain_block = plain;
        beat.byte_count = dbce_pkg::COUNT_W'(count);
        beat.last = is_last;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= beat;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(beat);
        sent_items++;
        if (is_last)
            msg_count++;
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [63:0] key_v;
        logic [63:0] iv_v;
        int          msg_len;
        sb = new();
        sb.clear();
        idle_en = 1'b1;
        hold_off_req = 1'b0;
        idle_cycles = 0;
        sent_items = 0;
        msg_count = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = dbce_pkg::CFG_KEY;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Known-answer check of the predictor itself
        write_reg(dbce_pkg::CFG_KEY, 64'h133457799BBCDFF1);
        write_reg(dbce_pkg::CFG_IV, 64'h0);
        write_reg(dbce_pkg::CFG_MODE, dbce_pkg::MODE_ECB);
        if (sb.des_block(64'h0123456789ABCDEF) !== 64'h85E813540F0AB405)
            sb.report_mismatch("DES known answer", sb.des_block(64'h0123456789ABCDEF),
                               64'h85E813540F0AB405);

        // Directed: extremes, every pad length, oversize count, full last block
        send_beat(64'h0123456789ABCDEF, 8, 1'b0);
        send_beat(64'h0, 0, 1'b0);
        send_beat('1, 15, 1'b0);
        for (int n = 0; n <= 8; n++) send_beat(64'hA5C3_0F96_1234_FEDC, n, 1'b1);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 9, 1'b1);
        send_beat(64'h0, 15, 1'b1);
        drain();
        write_reg(dbce_pkg::CFG_MODE, dbce_pkg::MODE_CBC);
        write_reg(dbce_pkg::CFG_IV, 64'hFEDCBA9876543210);
        send_beat(64'h0, 3, 1'b0);
        send_beat('1, 8, 1'b0);
        send_beat(64'h5555AAAA5555AAAA, 5, 1'b1);
        send_beat('1, 8, 1'b1);
        drain();
        write_reg(dbce_pkg::CFG_MODE, dbce_pkg::MODE_PCBC);
        send_beat(64'h0, 8, 1'b0);
        send_beat('1, 2, 1'b0);
        send_beat(64'h0123456789ABCDEF, 8, 1'b1);
        send_beat('1, 0, 1'b1);
        drain();

        // Random phases, each with its own key and IV; the mode steps through all four codes
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            key_v = (ph == 0) ? 64'h0 : (ph == 1) ? '1 : rand64();
            iv_v = (ph == 0) ? '1 : (ph == 1) ? 64'h0 : rand64();
            write_reg(dbce_pkg::CFG_KEY, key_v);
            write_reg(dbce_pkg::CFG_IV, iv_v);
            write_reg(dbce_pkg::CFG_MODE, 2'(ph % 4));
            if (ph == NUM_PHASES - 1)
                idle_en = 1'b0;
            if (ph == 3)
                hold_off_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS;)
            begin
                msg_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
                for (int j = 0; j < msg_len; j++)
                begin
                    if (j == msg_len - 1)
                        send_beat(rand64(), $urandom_range(0, 15), 1'b1);
                    else
                        send_beat(rand64(), $urandom_range(0, 15), 1'b0);
                    k++;
                end
            end
            drain();
        end

        $display("covered %0d blocks in %0d messages over %0d key/IV/mode settings",
                 sent_items, msg_count, NUM_PHASES + 3);
        $display("checked %0d cipher beats, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS des_block_chaining_encrypt_top");
        else
            $display("FAIL des_block_chaining_encrypt_top");
        $finish;
    end
endmodule
